// ===== design/mcpid_pkg.sv =====
// Shared widths, register codes, state layout and fixed-point helpers for the PID speed loop.
package mcpid_pkg;

  localparam int CH_W      = 2;
  localparam int SPEED_W   = 16;
  localparam int GAIN_W    = 16;
  localparam int LIMIT_W   = 15;
  localparam int ERR_W     = SPEED_W + 1;
  localparam int DIFF_W    = ERR_W + 1;
  localparam int INTEG_W   = 16;
  localparam int DRIVE_W   = 16;
  localparam int PROD_W    = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W     = PROD_W + 1;
  localparam int FRAC_BITS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_DERIV_GAIN  = 3'd2,
    REG_INTEG_LIMIT = 3'd3,
    REG_OUT_LIMIT   = 3'd4
  } cfg_reg_t;

  // Per-channel state word held in the state RAM.
  typedef struct packed {
    logic signed [ERR_W-1:0]   last_error;
    logic signed [INTEG_W-1:0] integ;
  } chan_state_t;

  // Scale a product of a Q8.8 gain back to integer, round half up.
  function automatic logic signed [ACC_W-1:0] round_q8(input logic signed [PROD_W-1:0] p);
    logic signed [ACC_W-1:0] t;
    t = ACC_W'(p) + ACC_W'(1 << (FRAC_BITS - 1));
    return t >>> FRAC_BITS;
  endfunction

  // Clamp to +/-lim.
  function automatic logic signed [ACC_W-1:0] clamp_sym(input logic signed [ACC_W-1:0] v,
                                                      input logic [LIMIT_W-1:0] lim);
    logic signed [ACC_W-1:0] l;
    l = $signed(ACC_W'(lim));
    if (v > l) begin
      return l;
    end else if (v < -l) begin
      return -l;
    end
    return v;
  endfunction

endpackage

// ===== design/mcpid_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mcpid_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read-first: a same-address write is not seen until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/multi_channel_pid_speed_loop.sv =====
// Top level: multi-channel positional PID speed loop with per-channel state in RAM.
//
//   channel  handshake             payload
//   -------  --------------------  -------------------------------------------
//   cfg      cfg_valid/cfg_ready   cfg_index, cfg_data (gains and limits)
//   in       in_valid/in_stall     channel, measured_speed, target_speed
//   out      out_valid/out_stall   channel_out, drive
//
// One item per cycle sustained while out_stall is low; an accepted item goes through state
// read, multiply, then combine and clamp into the output register.
// Each stage holds while the output register is full and stalled; in_stall follows it.
// Reset clears the config registers and the per-channel valid bits; a channel whose
// valid bit is clear reads as zero state, so no clearing pass is needed. While rst is
// high, in_stall is high and cfg_ready is low.
module multi_channel_pid_speed_loop #(
  parameter int CHANNELS = 4
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [mcpid_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mcpid_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mcpid_pkg::CH_W-1:0]             channel,
  input  logic signed [mcpid_pkg::SPEED_W-1:0]   measured_speed,
  input  logic signed [mcpid_pkg::SPEED_W-1:0]   target_speed,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mcpid_pkg::CH_W-1:0]             channel_out,
  output logic signed [mcpid_pkg::DRIVE_W-1:0]   drive
);

  localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ST_W   = $bits(mcpid_pkg::chan_state_t);

  // ---------------------------------------------------------------------------
  // Configuration registers; the port never back-pressures outside reset.
  // ---------------------------------------------------------------------------
  logic [mcpid_pkg::GAIN_W-1:0]  prop_gain;
  logic [mcpid_pkg::GAIN_W-1:0]  integ_gain;
  logic [mcpid_pkg::GAIN_W-1:0]  deriv_gain;
  logic [mcpid_pkg::LIMIT_W-1:0] integ_limit;
  logic [mcpid_pkg::LIMIT_W-1:0] out_limit;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain   <= '0;
      integ_gain  <= '0;
      deriv_gain  <= '0;
      integ_limit <= '0;
      out_limit   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (mcpid_pkg::cfg_reg_t'(cfg_index))
        mcpid_pkg::REG_PROP_GAIN:   prop_gain   <= cfg_data;
        mcpid_pkg::REG_INTEG_GAIN:  integ_gain  <= cfg_data;
        mcpid_pkg::REG_DERIV_GAIN:  deriv_gain  <= cfg_data;
        mcpid_pkg::REG_INTEG_LIMIT: integ_limit <= cfg_data[mcpid_pkg::LIMIT_W-1:0];
        mcpid_pkg::REG_OUT_LIMIT:   out_limit   <= cfg_data[mcpid_pkg::LIMIT_W-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: every stage advances together unless the output is stalled.
  // ---------------------------------------------------------------------------
  logic adv;
  logic accept;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = rst || !adv;
  assign accept   = in_valid && !in_stall;

  // ---------------------------------------------------------------------------
  // Stage 0: form the error, issue the state read.
  // ---------------------------------------------------------------------------
  logic [31:0]                               ch_wide;
  logic [ADDR_W-1:0]                         rd_addr;
  logic                                      in_range0;
  logic signed [mcpid_pkg::ERR_W-1:0]        err0;

  assign ch_wide   = 32'(channel);
  assign rd_addr   = ch_wide[ADDR_W-1:0];
  assign in_range0 = ch_wide < 32'(CHANNELS);
  assign err0      = mcpid_pkg::ERR_W'(target_speed) - mcpid_pkg::ERR_W'(measured_speed);

  // Write-back port, driven from stage 2.
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  mcpid_pkg::chan_state_t wr_state;
  logic [ST_W-1:0]        ram_rdata;

  mcpid_ram #(
    .WIDTH (ST_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_state),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // One valid bit per channel: a channel never written reads as zero state.
  logic [CHANNELS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 registers. A write landing on the same entry at the read edge is
  // captured here, since the RAM returns the old word in that case.
  // ---------------------------------------------------------------------------
  logic                               s1_valid;
  logic [mcpid_pkg::CH_W-1:0]         s1_ch;
  logic [ADDR_W-1:0]                  s1_addr;
  logic                               s1_inr;
  logic signed [mcpid_pkg::ERR_W-1:0] s1_err;
  logic                               s1_vld;
  logic                               s1_col;
  mcpid_pkg::chan_state_t             s1_col_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch        <= channel;
      s1_addr      <= rd_addr;
      s1_inr       <= in_range0;
      s1_err       <= err0;
      s1_vld       <= in_range0 && vld[rd_addr];
      s1_col       <= wr_en && (wr_addr == rd_addr);
      s1_col_state <= wr_state;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: resolve the stored state, forward the error of the item ahead,
  // and run the three gain multiplies.
  // ---------------------------------------------------------------------------
  logic                                s2_valid;
  logic [mcpid_pkg::CH_W-1:0]          s2_ch;
  logic [ADDR_W-1:0]                   s2_addr;
  logic                                s2_inr;
  logic signed [mcpid_pkg::ERR_W-1:0]  s2_err;
  logic signed [mcpid_pkg::INTEG_W-1:0] s2_integ;
  logic signed [mcpid_pkg::PROD_W-1:0] s2_p_prod;
  logic signed [mcpid_pkg::PROD_W-1:0] s2_i_prod;
  logic signed [mcpid_pkg::PROD_W-1:0] s2_d_prod;

  mcpid_pkg::chan_state_t              st1;
  logic signed [mcpid_pkg::ERR_W-1:0]  prev_err;
  logic signed [mcpid_pkg::DIFF_W-1:0] diff1;
  logic signed [mcpid_pkg::PROD_W-1:0] p_prod;
  logic signed [mcpid_pkg::PROD_W-1:0] i_prod;
  logic signed [mcpid_pkg::PROD_W-1:0] d_prod;

  always_comb begin
    if (s1_col) begin
      st1 = s1_col_state;
    end else if (s1_vld) begin
      st1 = mcpid_pkg::chan_state_t'(ram_rdata);
    end else begin
      st1 = '0;
    end
  end

  // The item one ahead has not written yet: take its error from stage 2.
  assign prev_err = (s2_valid && s2_inr && (s2_addr == s1_addr)) ? s2_err : st1.last_error;
  assign diff1    = mcpid_pkg::DIFF_W'(s1_err) - mcpid_pkg::DIFF_W'(prev_err);

  assign p_prod = mcpid_pkg::PROD_W'($signed({1'b0, prop_gain}))
                * mcpid_pkg::PROD_W'(s1_err);
  assign i_prod = mcpid_pkg::PROD_W'($signed({1'b0, integ_gain}))
                * mcpid_pkg::PROD_W'(s1_err);
  assign d_prod = mcpid_pkg::PROD_W'($signed({1'b0, deriv_gain}))
                * mcpid_pkg::PROD_W'(diff1);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ch     <= s1_ch;
      s2_addr   <= s1_addr;
      s2_inr    <= s1_inr;
      s2_err    <= s1_err;
      s2_integ  <= st1.integ;
      s2_p_prod <= p_prod;
      s2_i_prod <= i_prod;
      s2_d_prod <= d_prod;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: round the terms, update and clamp the integrator, sum and clamp.
  // The integrator of the item one ahead arrives through the write-back copy.
  // ---------------------------------------------------------------------------
  logic                                 wb_valid;
  logic [ADDR_W-1:0]                    wb_addr;
  logic signed [mcpid_pkg::INTEG_W-1:0] wb_integ;

  logic signed [mcpid_pkg::INTEG_W-1:0] integ_old;
  logic signed [mcpid_pkg::ACC_W-1:0]   p_term;
  logic signed [mcpid_pkg::ACC_W-1:0]   i_term;
  logic signed [mcpid_pkg::ACC_W-1:0]   d_term;
  logic signed [mcpid_pkg::ACC_W-1:0]   integ_sum;
  logic signed [mcpid_pkg::INTEG_W-1:0] integ_new;
  logic signed [mcpid_pkg::ACC_W-1:0]   pid_sum;
  logic signed [mcpid_pkg::DRIVE_W-1:0] drive_next;

  assign integ_old = (wb_valid && (wb_addr == s2_addr)) ? wb_integ : s2_integ;
  assign p_term    = mcpid_pkg::round_q8(s2_p_prod);
  assign i_term    = mcpid_pkg::round_q8(s2_i_prod);
  assign d_term    = mcpid_pkg::round_q8(s2_d_prod);
  assign integ_sum = mcpid_pkg::ACC_W'(integ_old) + i_term;
  assign integ_new = mcpid_pkg::INTEG_W'(mcpid_pkg::clamp_sym(integ_sum, integ_limit));
  assign pid_sum   = p_term + mcpid_pkg::ACC_W'(integ_new) + d_term;

  // Channels beyond the configured count give zero drive and leave state alone.
  assign drive_next = s2_inr ? mcpid_pkg::DRIVE_W'(mcpid_pkg::clamp_sym(pid_sum, out_limit))
                             : '0;

  assign wr_en               = adv && s2_valid && s2_inr;
  assign wr_addr             = s2_addr;
  assign wr_state.last_error = s2_err;
  assign wr_state.integ      = integ_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (adv) begin
      wb_valid <= s2_valid && s2_inr;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wb_addr  <= s2_addr;
      wb_integ <= integ_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      channel_out <= s2_ch;
      drive       <= drive_next;
    end
  end

endmodule
